### design/bcfm_pkg.sv
package bcfm_pkg;

  localparam int unsigned Cells = 13;
  localparam int unsigned CellIdxW = 4;
  localparam logic [12:0] TopMv = 13'd5000;
  localparam logic [12:0] FieldOffsetMv = 13'd1000;
  localparam logic [13:0] NoCellLowMv = 14'd10000;
  localparam logic [7:0] SensorAbsent = 8'hFD;
  localparam logic [7:0] BalanceLimit = 8'hDF;
  localparam logic [7:0] ProbeLimit = 8'hF0;
  localparam logic signed [8:0] OffsetA = 9'sd86;
  localparam logic signed [8:0] OffsetB = 9'sd80;

  localparam logic [1:0] ActVolt = 2'd0;
  localparam logic [1:0] ActTemp = 2'd1;
  localparam logic [1:0] ActRead = 2'd2;
  localparam logic [1:0] ActNone = 2'd3;

  localparam logic [0:0] CfgIgnore = 1'b0;
  localparam logic [0:0] CfgSelect = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StMarks,
    StWalk,
    StDiv,
    StOut
  } state_e;

  // Divider handshake between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [16:0] dividend;
    logic [3:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [12:0] quotient;
  } div_rsp_t;

endpackage

### design/battery_cell_frame_monitor_unit.sv
// Channel  Dir  Handshake              Content
// s_axis   in   s_axis_tvalid/tready   action, group, temp_format, payload, cell_index
// m_axis   out  m_axis_tvalid/tready   cell statistics, temperatures, marks, reads
// cfg      in   cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
// After acceptance the block updates the temperature marks, walks the 13
// cells and runs the divider (load, 17 quotient bits, done); with no counted
// cell the divider is skipped. No new frame is taken while one is in work:
// s_axis_tready is low from acceptance until the result beat is taken and
// the block is back in idle; a stalled result holds in the output register.
// Reset sets cells to zero, lowest marks to 5000 and temperature marks to
// 400 and -200 half degrees.
module battery_cell_frame_monitor_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] action, [3:2] group, [67:4] payload, [71:68] cell_index
  input  logic [71:0]  s_axis_tdata,
  // [0] temp_format
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [13:0] cell_low_mv, [26:14] cell_high_mv, [43:27] module_mv,
  // [47:44] valid_cells, [60:48] average_mv, [69:61] temp_low_now,
  // [78:70] temp_high_now, [88:79] temp_lowest_seen,
  // [97:89] temp_highest_seen, [113:98] balance_bits,
  // [126:114] read_lowest_mv, [139:127] read_highest_mv
  output logic [143:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [12:0]  cfg_data_i
);

  localparam int unsigned N = bcfm_pkg::Cells;
  localparam logic [bcfm_pkg::CellIdxW-1:0] LastCell = bcfm_pkg::CellIdxW'(N - 1);

  bcfm_pkg::state_e state_q, state_d;

  logic [12:0] ignore_q;
  logic [1:0]  sel_q;
  logic [12:0] cell_q [N];
  logic [12:0] lo_mark_q [N];
  logic [12:0] hi_mark_q [N];
  logic signed [8:0] sens_q [3];
  logic signed [9:0] tlo_mark_q;
  logic signed [8:0] thi_mark_q;
  logic [15:0] bal_q;
  logic        ftype_q;

  logic [1:0]  act_q;
  logic [3:0]  cidx_q;
  logic [bcfm_pkg::CellIdxW-1:0] idx_q;
  logic [13:0] low_q;
  logic [12:0] high_q;
  logic [16:0] sum_q;
  logic [3:0]  cnt_q;
  logic [143:0] out_q;
  logic        ovalid_q;

  bcfm_pkg::div_req_t div_req;
  bcfm_pkg::div_rsp_t div_rsp;

  bcfm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic [1:0]  in_act, in_grp;
  logic [63:0] pl;
  logic [7:0]  b [8];
  logic [11:0] fld [4];
  logic signed [8:0] t_low, t_high;
  logic signed [10:0] tsum;

  assign in_act = s_axis_tdata[1:0];
  assign in_grp = s_axis_tdata[3:2];
  assign pl     = s_axis_tdata[67:4];
  always_comb begin
    for (int k = 0; k < 8; k++) b[k] = pl[8*k +: 8];
  end
  assign fld[0] = {b[2], b[1][7:4]};
  assign fld[1] = {b[4][3:0], b[3]};
  assign fld[2] = {b[5], b[4][7:4]};
  assign fld[3] = {b[7][3:0], b[6]};

  // Present temperatures from the stored sensors.
  always_comb begin
    tsum = 11'(sens_q[0]) + 11'(sens_q[1]) + 11'(sens_q[2]);
    if (!ftype_q) begin
      t_low  = sens_q[0];
      t_high = sens_q[0];
    end else if (sel_q != 2'd0) begin
      t_low  = sens_q[2'(sel_q - 2'd1) == 2'd3 ? 2'd0 : 2'(sel_q - 2'd1)];
      t_high = t_low;
    end else begin
      t_high = (sens_q[0] < sens_q[1]) ? sens_q[1] : sens_q[0];
      t_low  = '0;
      if (!(tsum <= 11'sd3 || sens_q[0] == 9'sd1 || sens_q[1] == 9'sd1 ||
            sens_q[2] == 9'sd1)) begin
        if (sens_q[0] >= 9'sd2 && sens_q[0] < sens_q[1] && sens_q[0] < sens_q[2])
          t_low = sens_q[0];
        else if (sens_q[1] >= 9'sd2 && sens_q[1] < sens_q[0] && sens_q[1] < sens_q[2])
          t_low = sens_q[1];
        else if (sens_q[2] >= 9'sd2 && sens_q[2] < sens_q[1] && sens_q[2] < sens_q[0])
          t_low = sens_q[2];
      end
    end
  end

  logic [12:0] cur;
  assign cur = cell_q[idx_q];

  logic div_started_q;

  always_comb begin
    state_d = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = sum_q;
    div_req.divisor  = cnt_q;
    if (state_q == bcfm_pkg::StDiv && !div_started_q && cnt_q != 4'd0)
      div_req.start = 1'b1;
    case (state_q)
      bcfm_pkg::StIdle:  if (s_axis_tvalid) state_d = bcfm_pkg::StMarks;
      bcfm_pkg::StMarks: state_d = bcfm_pkg::StWalk;
      bcfm_pkg::StWalk:  if (idx_q == LastCell) state_d = bcfm_pkg::StDiv;
      bcfm_pkg::StDiv: begin
        if (cnt_q == 4'd0) state_d = bcfm_pkg::StOut;
        else if (div_rsp.done) state_d = bcfm_pkg::StOut;
      end
      bcfm_pkg::StOut: if (m_axis_tready) state_d = bcfm_pkg::StIdle;
      default: state_d = bcfm_pkg::StIdle;
    endcase
  end

  assign s_axis_tready = (state_q == bcfm_pkg::StIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcfm_pkg::StIdle;
      ignore_q <= '0;
      sel_q <= '0;
      for (int k = 0; k < N; k++) begin
        cell_q[k] <= '0;
        lo_mark_q[k] <= bcfm_pkg::TopMv;
        hi_mark_q[k] <= '0;
      end
      for (int k = 0; k < 3; k++) sens_q[k] <= '0;
      tlo_mark_q <= 10'sd400;
      thi_mark_q <= -9'sd200;
      bal_q <= '0;
      ftype_q <= 1'b1;
      ovalid_q <= 1'b0;
      div_started_q <= 1'b0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == bcfm_pkg::CfgIgnore) ignore_q <= cfg_data_i;
        else sel_q <= cfg_data_i[1:0];
      end
      case (state_q)
        bcfm_pkg::StIdle: begin
          idx_q <= '0;
          div_started_q <= 1'b0;
          if (s_axis_tvalid) begin
            if (in_act == bcfm_pkg::ActVolt) begin
              for (int k = 0; k < 4; k++) begin
                if ((in_grp != 2'd3 || k == 0) && (4 * in_grp + k) < N)
                  cell_q[{in_grp, 2'(k)}] <= fld[k] + bcfm_pkg::FieldOffsetMv;
              end
            end else if (in_act == bcfm_pkg::ActTemp) begin
              if (s_axis_tuser) begin
                ftype_q <= 1'b1;
                if (b[7] == bcfm_pkg::SensorAbsent) begin
                  if (b[2] != bcfm_pkg::SensorAbsent)
                    sens_q[0] <= $signed({1'b0, b[2]}) - bcfm_pkg::OffsetB;
                end else begin
                  if (b[0] < bcfm_pkg::BalanceLimit) begin
                    sens_q[0] <= $signed({1'b0, b[0]}) - bcfm_pkg::OffsetA;
                    bal_q <= {b[3], b[2]};
                  end else begin
                    sens_q[0] <= $signed({1'b0, b[3]}) - bcfm_pkg::OffsetA;
                  end
                  sens_q[1] <= (b[4] < bcfm_pkg::ProbeLimit) ?
                               $signed({1'b0, b[4]}) - bcfm_pkg::OffsetA : 9'sd0;
                  sens_q[2] <= (b[5] < bcfm_pkg::ProbeLimit) ?
                               $signed({1'b0, b[5]}) - bcfm_pkg::OffsetA : 9'sd0;
                end
              end else begin
                ftype_q <= 1'b0;
                sens_q[0] <= $signed({1'b0, b[5][3:0], b[4][7:4]}) - bcfm_pkg::OffsetB;
              end
            end
          end
        end
        bcfm_pkg::StMarks: begin
          if (act_q == bcfm_pkg::ActVolt) begin
            if (10'(t_low) < tlo_mark_q) tlo_mark_q <= 10'(t_low);
            if (t_high > thi_mark_q) thi_mark_q <= t_high;
          end
        end
        bcfm_pkg::StWalk: begin
          // Visit one cell per cycle: marks and statistics.
          if (act_q == bcfm_pkg::ActVolt) begin
            if (lo_mark_q[idx_q] > cur && cur >= ignore_q) lo_mark_q[idx_q] <= cur;
            if (hi_mark_q[idx_q] < cur && cur < bcfm_pkg::TopMv) hi_mark_q[idx_q] <= cur;
          end
          if (idx_q != LastCell) idx_q <= idx_q + 1'b1;
        end
        bcfm_pkg::StDiv: if (div_req.start) div_started_q <= 1'b1;
        default: ;
      endcase
      if (state_q == bcfm_pkg::StDiv && state_d == bcfm_pkg::StOut) ovalid_q <= 1'b1;
      else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bcfm_pkg::StIdle) begin
      act_q  <= in_act;
      cidx_q <= s_axis_tdata[71:68];
      low_q  <= bcfm_pkg::NoCellLowMv;
      high_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
    end
    if (state_q == bcfm_pkg::StWalk && cur > ignore_q) begin
      if (14'(cur) < low_q) low_q <= 14'(cur);
      if (cur < bcfm_pkg::TopMv) begin
        if (cur > high_q) high_q <= cur;
        sum_q <= sum_q + 17'(cur);
        cnt_q <= cnt_q + 4'd1;
      end
    end
    if (state_q == bcfm_pkg::StDiv && state_d == bcfm_pkg::StOut) begin
      out_q[13:0]    <= low_q;
      out_q[26:14]   <= high_q;
      out_q[43:27]   <= sum_q;
      out_q[47:44]   <= cnt_q;
      out_q[60:48]   <= (cnt_q == 4'd0) ? 13'd0 : div_rsp.quotient;
      out_q[69:61]   <= t_low;
      out_q[78:70]   <= t_high;
      out_q[88:79]   <= tlo_mark_q;
      out_q[97:89]   <= thi_mark_q;
      out_q[113:98]  <= bal_q;
      out_q[126:114] <= (act_q == bcfm_pkg::ActRead && cidx_q < 4'(N)) ?
                        lo_mark_q[cidx_q] : 13'd0;
      out_q[139:127] <= (act_q == bcfm_pkg::ActRead && cidx_q < 4'(N)) ?
                        hi_mark_q[cidx_q] : 13'd0;
      out_q[143:140] <= '0;
    end
  end

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accepting while result pending");
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> state_q == bcfm_pkg::StOut) else $error("valid outside output");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bcfm_pkg::StWalk |-> idx_q <= LastCell) else $error("walk overran");

endmodule

### design/bcfm_divider.sv
module bcfm_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bcfm_pkg::div_req_t  req_i,
  output bcfm_pkg::div_rsp_t  rsp_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] quo_q, quo_d;
  logic [4:0]  rem_q, rem_d;
  logic [3:0]  dsr_q, dsr_d;
  logic        done_q, done_d;
  logic [5:0]  trial;

  // One quotient bit per cycle, restoring.
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[16]} - {2'b00, dsr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd17;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!trial[5]) begin
        rem_d = trial[4:0];
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = {rem_q[3:0], quo_q[16]};
        quo_d = {quo_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[12:0];

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider busy at done");

endmodule

### tb/battery_cell_frame_monitor_unit_tb.sv
`timescale 1ns / 1ps

module battery_cell_frame_monitor_unit_tb;

  localparam int NumFields = 12;
  localparam int FieldOff[NumFields] = '{0, 14, 27, 44, 48, 61, 70, 79, 89, 98, 114, 127};
  localparam int FieldW[NumFields] = '{14, 13, 17, 4, 13, 9, 9, 10, 9, 16, 13, 13};

  class frame_scoreboard;
    logic [143:0] expected_q[$];
    int errors;
    int results_seen;
    int ignore_mv;
    int sel;
    int cell_mv[bcfm_pkg::Cells];
    int cell_lo[bcfm_pkg::Cells];
    int cell_hi[bcfm_pkg::Cells];
    int sensor[3];
    int lo_mark;
    int hi_mark;
    int balance;
    int ftype;

    function new();
      errors = 0;
      results_seen = 0;
      ignore_mv = 0;
      sel = 0;
      for (int i = 0; i < bcfm_pkg::Cells; i++) begin
        cell_mv[i] = 0;
        cell_lo[i] = bcfm_pkg::TopMv;
        cell_hi[i] = 0;
      end
      sensor = '{0, 0, 0};
      lo_mark = 400;
      hi_mark = -200;
      balance = 0;
      ftype = 1;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int temp_high();
      if (ftype == 0) return sensor[0];
      if (sel != 0) return sensor[sel-1];
      return (sensor[0] < sensor[1]) ? sensor[1] : sensor[0];
    endfunction

    function int temp_low();
      int t0, t1, t2;
      t0 = sensor[0];
      t1 = sensor[1];
      t2 = sensor[2];
      if (ftype == 0) return t0;
      if (sel != 0) return sensor[sel-1];
      if (t0 + t1 + t2 <= 3 || t0 == 1 || t1 == 1 || t2 == 1) return 0;
      if (t0 >= 2 && t0 < t1 && t0 < t2) return t0;
      if (t1 >= 2 && t1 < t0 && t1 < t2) return t1;
      if (t2 >= 2 && t2 < t1 && t2 < t0) return t2;
      return 0;
    endfunction

    function void put_cell(int idx, int field);
      if (idx < bcfm_pkg::Cells)
        cell_mv[idx] = (field & 12'hFFF) + bcfm_pkg::FieldOffsetMv;
    endfunction

    function void note(logic [1:0] act, logic [1:0] grp, logic fmt, logic [63:0] p,
                       logic [3:0] cidx);
      int b[8];
      int t, lo, hi, sum, cnt, rd_lo, rd_hi, base;
      int val[NumFields];
      logic [143:0] vec;
      for (int i = 0; i < 8; i++) b[i] = p[8*i +: 8];
      rd_lo = 0;
      rd_hi = 0;
      if (act == bcfm_pkg::ActVolt) begin
        base = 4 * grp;
        put_cell(base, (b[1] >> 4) | (b[2] << 4));
        if (grp != 2'd3) begin
          put_cell(base + 1, b[3] | ((b[4] & 8'h0F) << 8));
          put_cell(base + 2, (b[4] >> 4) | (b[5] << 4));
          put_cell(base + 3, b[6] | ((b[7] & 8'h0F) << 8));
        end
        t = temp_low();
        if (t < lo_mark) lo_mark = t;
        t = temp_high();
        if (t > hi_mark) hi_mark = t;
        for (int i = 0; i < bcfm_pkg::Cells; i++) begin
          if (cell_lo[i] > cell_mv[i] && cell_mv[i] >= ignore_mv) cell_lo[i] = cell_mv[i];
          if (cell_hi[i] < cell_mv[i] && cell_mv[i] < bcfm_pkg::TopMv)
            cell_hi[i] = cell_mv[i];
        end
      end else if (act == bcfm_pkg::ActTemp) begin
        if (fmt) begin
          ftype = 1;
          if (b[7] == bcfm_pkg::SensorAbsent) begin
            if (b[2] != bcfm_pkg::SensorAbsent) sensor[0] = b[2] - bcfm_pkg::OffsetB;
          end else begin
            if (b[0] < bcfm_pkg::BalanceLimit) begin
              sensor[0] = b[0] - bcfm_pkg::OffsetA;
              balance = b[2] | (b[3] << 8);
            end else begin
              sensor[0] = b[3] - bcfm_pkg::OffsetA;
            end
            sensor[1] = (b[4] < bcfm_pkg::ProbeLimit) ? b[4] - bcfm_pkg::OffsetA : 0;
            sensor[2] = (b[5] < bcfm_pkg::ProbeLimit) ? b[5] - bcfm_pkg::OffsetA : 0;
          end
        end else begin
          ftype = 0;
          sensor[0] = (((b[5] & 8'h0F) << 4) | (b[4] >> 4)) - bcfm_pkg::OffsetB;
        end
      end else if (act == bcfm_pkg::ActRead && cidx < bcfm_pkg::Cells) begin
        rd_lo = cell_lo[cidx];
        rd_hi = cell_hi[cidx];
      end
      lo = bcfm_pkg::NoCellLowMv;
      hi = 0;
      sum = 0;
      cnt = 0;
      for (int i = 0; i < bcfm_pkg::Cells; i++) begin
        if (cell_mv[i] > ignore_mv) begin
          if (cell_mv[i] < lo) lo = cell_mv[i];
          if (cell_mv[i] < bcfm_pkg::TopMv) begin
            if (cell_mv[i] > hi) hi = cell_mv[i];
            sum += cell_mv[i];
            cnt++;
          end
        end
      end
      val = '{lo, hi, sum, cnt, (cnt != 0) ? sum / cnt : 0, temp_low(), temp_high(),
              lo_mark, hi_mark, balance, rd_lo, rd_hi};
      vec = '0;
      for (int f = 0; f < NumFields; f++)
        for (int k = 0; k < FieldW[f]; k++) vec[FieldOff[f] + k] = val[f][k];
      expected_q.push_back(vec);
    endfunction

    task check(logic [143:0] got);
      logic [143:0] want;
      logic [31:0] a, e;
      if (expected_q.size() == 0) begin
        report("result beat with no frame pending");
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      for (int f = 0; f < NumFields; f++) begin
        a = '0;
        e = '0;
        for (int k = 0; k < FieldW[f]; k++) begin
          a[k] = got[FieldOff[f] + k];
          e[k] = want[FieldOff[f] + k];
        end
        if (a !== e) report($sformatf("result %0d field %0d: got %h want %h",
                                      results_seen, f, a, e));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = bcfm_pkg::CfgIgnore;
  logic [12:0] cfg_data_i = '0;

  frame_scoreboard sb = new();
  int frames_sent = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  battery_cell_frame_monitor_unit i_dut (.*);

  // Track accepted frames and check result beats at the rising edge.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      sb.note(s_axis_tdata[1:0], s_axis_tdata[3:2], s_axis_tuser, s_axis_tdata[67:4],
              s_axis_tdata[71:68]);
    if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
  end

  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold == 0) begin
        hold = 300;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = quiet || ($urandom_range(99) >= 32);
      end
    end
  end

  task write_reg(logic [0:0] idx, int data);
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = 13'(data);
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == bcfm_pkg::CfgIgnore) sb.ignore_mv = data;
    else sb.sel = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task send_frame(logic [1:0] act, logic [1:0] grp, logic fmt, logic [63:0] p,
                  logic [3:0] cidx);
    if (!quiet && $urandom_range(99) < 32) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
    s_axis_tdata = {cidx, p, grp, act};
    s_axis_tuser = fmt;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    frames_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task send_random();
    logic [63:0] p;
    int r;
    logic [1:0] act;
    p = {$urandom, $urandom};
    r = $urandom_range(99);
    act = (r < 45) ? bcfm_pkg::ActVolt : (r < 75) ? bcfm_pkg::ActTemp :
          (r < 95) ? bcfm_pkg::ActRead : bcfm_pkg::ActNone;
    if (act == bcfm_pkg::ActTemp) begin
      // bias toward the sensor-absent, balance and probe-limit cases
      if ($urandom_range(3) == 0) p[63:56] = bcfm_pkg::SensorAbsent;
      if ($urandom_range(5) == 0) p[23:16] = bcfm_pkg::SensorAbsent;
      if ($urandom_range(1)) p[7:0] = 8'($urandom_range(100, 80));
      if ($urandom_range(1)) p[39:32] = 8'($urandom_range(100, 80));
      if ($urandom_range(1)) p[47:40] = 8'($urandom_range(100, 80));
    end
    send_frame(act, 2'($urandom), 1'($urandom), p, 4'($urandom));
  endtask

  initial begin : stim
    int sel_set[5] = '{0, 1, 2, 3, 0};
    int ign_set[5] = '{0, 5095, 3000, 1200, 4100};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_reg(bcfm_pkg::CfgIgnore, 0);
    write_reg(bcfm_pkg::CfgSelect, 0);
    // directed: field extremes, every action, special temperature bytes
    send_frame(bcfm_pkg::ActRead, 0, 0, '0, 0);
    send_frame(bcfm_pkg::ActVolt, 0, 0, '0, 0);
    send_frame(bcfm_pkg::ActVolt, 1, 0, '1, 0);
    send_frame(bcfm_pkg::ActVolt, 2, 0, 64'h0F0F_0F0F_0F0F_0F0F, 0);
    send_frame(bcfm_pkg::ActVolt, 3, 0, 64'h00FF_FFFF_FFFF_FFFF, 0);
    send_frame(bcfm_pkg::ActRead, 0, 0, '0, 12);
    send_frame(bcfm_pkg::ActRead, 0, 0, '0, 13);
    send_frame(bcfm_pkg::ActRead, 0, 0, '0, 15);
    send_frame(bcfm_pkg::ActTemp, 0, 1, 64'h0000_5A50_1234_5600, 0);
    send_frame(bcfm_pkg::ActTemp, 0, 1, 64'hFD00_0000_00FD_0000, 0);
    send_frame(bcfm_pkg::ActTemp, 0, 1, 64'hFD00_0000_0064_0000, 0);
    send_frame(bcfm_pkg::ActTemp, 0, 1, 64'h0000_F0F0_00AA_5500, 0);
    send_frame(bcfm_pkg::ActTemp, 0, 1, 64'h0000_6059_5800_0064, 0);
    send_frame(bcfm_pkg::ActTemp, 0, 1, 64'h0000_5C58_6400_00DF, 0);
    send_frame(bcfm_pkg::ActTemp, 0, 1, 64'h0000_5757_5557_0057, 0);
    send_frame(bcfm_pkg::ActVolt, 0, 0, 64'h0123_4567_89AB_CDEF, 0);
    send_frame(bcfm_pkg::ActTemp, 0, 0, 64'h0000_FFF0_0000_0000, 0);
    send_frame(bcfm_pkg::ActTemp, 0, 0, '0, 0);
    send_frame(bcfm_pkg::ActVolt, 1, 0, 64'h0000_0000_0000_0000, 0);
    send_frame(bcfm_pkg::ActNone, 0, 0, '1, 5);
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(bcfm_pkg::CfgIgnore, ign_set[ph]);
      write_reg(bcfm_pkg::CfgSelect, sel_set[ph]);
      for (int n = 0; n < 126; n++) begin
        quiet = (ph == 1 && n >= 30 && n < 90);
        if (ph == 3 && n == 40) hold_req = 1'b1;
        send_random();
      end
      quiet = 1'b0;
    end
    s_axis_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("Covered %0d frames and %0d result beats over five register settings,",
             frames_sent, sb.results_seen);
    $display("including a long output stall and random idling on both sides.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("battery_cell_frame_monitor_unit verification clean");
    end else begin
      $display("battery_cell_frame_monitor_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("battery_cell_frame_monitor_unit verification failed");
    $finish;
  end

endmodule
